[design/relative_offset_table_decoder_macros.svh]
// Assertion macros for the relative offset table decoder core
`ifndef RELATIVE_OFFSET_TABLE_DECODER_MACROS_SVH
`define RELATIVE_OFFSET_TABLE_DECODER_MACROS_SVH

// same-cycle implication
`define ROTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ROTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rotd_pkg.sv]
// Types and constants for the relative offset table decoder
package rotd_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORDS_W     = 30;
    localparam int ADDR_OUT_W  = 32;
    localparam int SUM_W       = 32;
    localparam int LEFT_W      = 2;
    localparam int FIELD_W     = 6;
    localparam int DEFAULT_ADDRESS_WIDTH = 32;

    // length code in the top two bits of an entry's first byte
    typedef enum logic [1:0] {
        LEN_PAD  = 2'd0,
        LEN_ONE  = 2'd1,
        LEN_TWO  = 2'd2,
        LEN_FOUR = 2'd3
    } len_code_t;

    typedef struct packed {
        logic [BYTE_W-1:0] table_byte;
        logic              last_byte;
    } item_t;

    typedef struct packed {
        logic                  entry_valid;
        logic [WORDS_W-1:0]    relative_words;
        logic [ADDR_OUT_W-1:0] patch_address;
        logic                  table_end;
    } result_t;

endpackage

[design/rotd_ifs.sv]
// Channel interfaces: table bytes in, results out, configuration writes
interface rotd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [rotd_pkg::BYTE_W-1:0] table_byte;
    logic                        last_byte;

    modport source (output valid, output table_byte, output last_byte, input ready);
    modport sink (input valid, input table_byte, input last_byte, output ready);
endinterface

interface rotd_result_if;
    logic                            valid;
    logic                            ready;
    logic                            entry_valid;
    logic [rotd_pkg::WORDS_W-1:0]    relative_words;
    logic [rotd_pkg::ADDR_OUT_W-1:0] patch_address;
    logic                            table_end;

    modport source (output valid, output entry_valid, output relative_words,
                    output patch_address, output table_end, input ready);
    modport sink (input valid, input entry_valid, input relative_words,
                  input patch_address, input table_end, output ready);
endinterface

interface rotd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rotd_pkg::ADDR_OUT_W-1:0] base_address;

    modport source (output valid, output base_address, input ready);
    modport sink (input valid, input base_address, output ready);
endinterface

[design/relative_offset_table_decoder.sv]
// Top level of the relative offset table decoder
// Takes one table byte per cycle and, for each completed 1, 2 or 4 byte entry,
// gives its relative word count and the absolute patch address base_address
// plus four times the running word sum; the byte marked last always gives a
// result with table_end set and then clears the decoder. A byte passes the
// input register and the single decode stage into the result register, which
// drives the result channel and holds it until it is taken. Sustained rate is
// one byte per cycle; input stalls only while the result register is full and
// not taken, and the decode stage with its running-sum add sets that figure.
// base_address is written through cfg and must only change while idle.
module relative_offset_table_decoder #(
    parameter int ADDRESS_WIDTH = rotd_pkg::DEFAULT_ADDRESS_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    rotd_byte_if.sink     tbl,
    rotd_cfg_if.sink      cfg,
    rotd_result_if.source res
);

    logic [rotd_pkg::ADDR_OUT_W-1:0] base_address_reg;
    logic                            item_valid;
    rotd_pkg::item_t                 item;
    logic                            advance;
    logic                            load;
    logic                            can_load;
    rotd_pkg::result_t               result;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            base_address_reg <= cfg.base_address;
        end
    end

    rotd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .tbl        (tbl),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rotd_core #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .base_address (base_address_reg),
        .out_can_load (can_load),
        .advance      (advance),
        .load         (load),
        .result       (result)
    );

    rotd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .can_load (can_load),
        .res      (res)
    );

endmodule

[design/rotd_in_reg.sv]
// Input register for table bytes
module rotd_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    rotd_byte_if.sink           tbl,
    input  logic                advance,
    output logic                item_valid,
    output rotd_pkg::item_t     item
);

    logic            valid_reg;
    rotd_pkg::item_t item_reg;

    // take a new word when empty or whenever the held one leaves this cycle
    assign tbl.ready  = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (tbl.valid && tbl.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl.valid && tbl.ready)
        begin
            item_reg.table_byte <= tbl.table_byte;
            item_reg.last_byte  <= tbl.last_byte;
        end
    end

endmodule

[design/rotd_core.sv]
// Entry decode, running word sum and patch address generation
`include "relative_offset_table_decoder_macros.svh"

module rotd_core #(
    parameter int ADDRESS_WIDTH = rotd_pkg::DEFAULT_ADDRESS_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  rotd_pkg::item_t                 item,
    input  logic [rotd_pkg::ADDR_OUT_W-1:0] base_address,
    input  logic                            out_can_load,
    output logic                            advance,
    output logic                            load,
    output rotd_pkg::result_t               result
);

    localparam int MASK_BITS = (ADDRESS_WIDTH < rotd_pkg::ADDR_OUT_W) ?
                               ADDRESS_WIDTH : rotd_pkg::ADDR_OUT_W;
    localparam logic [rotd_pkg::ADDR_OUT_W-1:0] ADDR_MASK =
        rotd_pkg::ADDR_OUT_W'((33'd1 << MASK_BITS) - 33'd1);

    logic [rotd_pkg::LEFT_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [rotd_pkg::WORDS_W-1:0]    partial_value_reg, partial_value_next;
    logic [rotd_pkg::SUM_W-1:0]      word_sum_reg;
    logic                            table_done_reg, table_done_next;

    rotd_pkg::len_code_t             code;
    logic                            done_entry;
    logic [rotd_pkg::WORDS_W-1:0]    value;
    logic [rotd_pkg::WORDS_W-1:0]    shifted;
    logic [rotd_pkg::LEFT_W-1:0]     left_dec;
    logic [rotd_pkg::SUM_W-1:0]      sum_new;
    logic [rotd_pkg::ADDR_OUT_W-1:0] addr;
    logic                            produce;

    assign code     = rotd_pkg::len_code_t'(item.table_byte[7:6]);
    assign shifted  = {partial_value_reg[rotd_pkg::WORDS_W-rotd_pkg::BYTE_W-1:0],
                       item.table_byte};
    assign left_dec = bytes_left_reg - 2'd1;

    always_comb
    begin
        done_entry         = 1'b0;
        value              = '0;
        bytes_left_next    = bytes_left_reg;
        partial_value_next = partial_value_reg;
        table_done_next    = table_done_reg;
        if (!table_done_reg)
        begin
            if (bytes_left_reg == 2'd0)
            begin
                case (code)
                    rotd_pkg::LEN_PAD:
                    begin
                        table_done_next = 1'b1;
                    end
                    rotd_pkg::LEN_ONE:
                    begin
                        value      = rotd_pkg::WORDS_W'(item.table_byte[5:0]);
                        done_entry = 1'b1;
                    end
                    rotd_pkg::LEN_TWO:
                    begin
                        partial_value_next = rotd_pkg::WORDS_W'(item.table_byte[5:0]);
                        bytes_left_next    = 2'd1;
                    end
                    rotd_pkg::LEN_FOUR:
                    begin
                        partial_value_next = rotd_pkg::WORDS_W'(item.table_byte[5:0]);
                        bytes_left_next    = 2'd3;
                    end
                    default:
                    begin
                        table_done_next = 1'b1;
                    end
                endcase
            end
            else
            begin
                bytes_left_next = left_dec;
                if (left_dec == 2'd0)
                begin
                    value              = shifted;
                    partial_value_next = '0;
                    done_entry         = 1'b1;
                end
                else
                begin
                    partial_value_next = shifted;
                end
            end
        end
    end

    // new sum first, then the address from it
    assign sum_new = word_sum_reg + rotd_pkg::SUM_W'(value);
    assign addr    = (base_address + {sum_new[rotd_pkg::SUM_W-3:0], 2'b00}) & ADDR_MASK;

    assign produce = done_entry || item.last_byte;
    assign advance = item_valid && (!produce || out_can_load);
    assign load    = advance && produce;

    assign result.entry_valid    = done_entry;
    assign result.relative_words = done_entry ? value : '0;
    assign result.patch_address  = done_entry ? addr : '0;
    assign result.table_end      = item.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg    <= '0;
            partial_value_reg <= '0;
            word_sum_reg      <= '0;
            table_done_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (item.last_byte)
            begin
                // clear for the next table
                bytes_left_reg    <= '0;
                partial_value_reg <= '0;
                word_sum_reg      <= '0;
                table_done_reg    <= 1'b0;
            end
            else
            begin
                bytes_left_reg    <= bytes_left_next;
                partial_value_reg <= partial_value_next;
                word_sum_reg      <= done_entry ? sum_new : word_sum_reg;
                table_done_reg    <= table_done_next;
            end
        end
    end

    `ROTD_ASSERT_NOW(a_done_no_open_entry, clk, rst_n, table_done_reg, bytes_left_reg == 2'd0, "entry open after table end")
    `ROTD_ASSERT_NEXT(a_last_clears, clk, rst_n, advance && item.last_byte, bytes_left_reg == 2'd0 && word_sum_reg == '0 && !table_done_reg, "state not cleared after last word")
    `ROTD_ASSERT_NEXT(a_sum_update, clk, rst_n, advance && done_entry && !item.last_byte, word_sum_reg == $past(sum_new), "word sum not updated")
    `ROTD_ASSERT_NOW(a_entry_not_done, clk, rst_n, load && result.entry_valid, !table_done_reg, "entry decoded after table end")

endmodule

[design/rotd_out_reg.sv]
// Result register towards the result channel
module rotd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rotd_pkg::result_t result,
    output logic              can_load,
    rotd_result_if.source     res
);

    logic              valid_reg;
    rotd_pkg::result_t result_reg;

    // free when empty or when the held word is taken this cycle
    assign can_load           = !valid_reg || res.ready;
    assign res.valid          = valid_reg;
    assign res.entry_valid    = result_reg.entry_valid;
    assign res.relative_words = result_reg.relative_words;
    assign res.patch_address  = result_reg.patch_address;
    assign res.table_end      = result_reg.table_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the relative offset table decoder
module tb_top;

    localparam int IDLE_LIMIT   = 200;
    localparam int SETTLE_WAIT  = 6;
    localparam int PHASE_ITEMS  = 80;
    localparam bit BY_HAND      = 1'b1;
    localparam bit PREDICTED    = 1'b0;

    typedef struct packed {
        logic [rotd_pkg::BYTE_W-1:0] table_byte;
        logic                        last_byte;
        logic                        by_hand;
        logic                        has_result;
        rotd_pkg::result_t           result;
    } directed_row_t;

    logic clk;
    logic rst_n;

    rotd_byte_if   tbl_if ();
    rotd_cfg_if    cfg_if ();
    rotd_result_if res_if ();

    relative_offset_table_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tbl   (tbl_if),
        .cfg   (cfg_if),
        .res   (res_if)
    );

    // decoder state as predicted
    logic [rotd_pkg::LEFT_W-1:0]     bytes_owed;
    logic [rotd_pkg::WORDS_W-1:0]    partial_words;
    logic [rotd_pkg::SUM_W-1:0]      word_total;
    logic                            table_ended;
    logic [rotd_pkg::ADDR_OUT_W-1:0] base_address_reg;

    rotd_pkg::result_t expected_results [$];
    int                error_count;
    int                idle_cycles;
    int                phase_items;
    bit                no_idle;

    // directed table: base address still at its reset value
    directed_row_t directed_rows [23] = '{
        '{8'h00, 1'b1, BY_HAND,   1'b1, '{1'b0, 30'd0,  32'd0,   1'b1}},
        '{8'h7F, 1'b0, BY_HAND,   1'b1, '{1'b1, 30'd63, 32'd252, 1'b0}},
        '{8'h40, 1'b0, BY_HAND,   1'b1, '{1'b1, 30'd0,  32'd252, 1'b0}},
        '{8'hBF, 1'b0, BY_HAND,   1'b0, '0},
        '{8'hFF, 1'b0, PREDICTED, 1'b0, '0},
        '{8'hFF, 1'b0, BY_HAND,   1'b0, '0},
        '{8'hFF, 1'b0, BY_HAND,   1'b0, '0},
        '{8'hFF, 1'b0, BY_HAND,   1'b0, '0},
        '{8'hFF, 1'b0, PREDICTED, 1'b0, '0},
        '{8'hC0, 1'b0, PREDICTED, 1'b0, '0},
        '{8'h00, 1'b0, PREDICTED, 1'b0, '0},
        '{8'h00, 1'b0, PREDICTED, 1'b0, '0},
        '{8'h00, 1'b0, PREDICTED, 1'b0, '0},
        '{8'h80, 1'b0, PREDICTED, 1'b0, '0},
        '{8'h00, 1'b0, PREDICTED, 1'b0, '0},
        '{8'h00, 1'b0, BY_HAND,   1'b0, '0},
        '{8'hFF, 1'b0, BY_HAND,   1'b0, '0},
        '{8'h41, 1'b1, BY_HAND,   1'b1, '{1'b0, 30'd0,  32'd0,   1'b1}},
        '{8'hC1, 1'b0, PREDICTED, 1'b0, '0},
        '{8'h02, 1'b1, BY_HAND,   1'b1, '{1'b0, 30'd0,  32'd0,   1'b1}},
        '{8'h81, 1'b0, PREDICTED, 1'b0, '0},
        '{8'h23, 1'b1, PREDICTED, 1'b0, '0},
        '{8'h45, 1'b1, BY_HAND,   1'b1, '{1'b1, 30'd5,  32'd20,  1'b1}}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic void clear_decoder();
        bytes_owed    = '0;
        partial_words = '0;
        word_total    = '0;
        table_ended   = 1'b0;
    endfunction

    // advance the predicted state by one byte; returns 1 when a word is due
    function automatic bit decode_table_byte(input logic [rotd_pkg::BYTE_W-1:0] b,
                                             input bit last,
                                             output rotd_pkg::result_t r);
        rotd_pkg::len_code_t          code;
        bit                           entry_done;
        logic [rotd_pkg::WORDS_W-1:0] value;
        entry_done = 1'b0;
        value      = '0;
        r          = '0;
        if (!table_ended)
        begin
            if (bytes_owed == 0)
            begin
                code = rotd_pkg::len_code_t'(b[7:6]);
                case (code)
                    rotd_pkg::LEN_PAD:
                        table_ended = 1'b1;
                    rotd_pkg::LEN_ONE:
                    begin
                        value      = {24'd0, b[rotd_pkg::FIELD_W-1:0]};
                        entry_done = 1'b1;
                    end
                    default:
                    begin
                        partial_words = {24'd0, b[rotd_pkg::FIELD_W-1:0]};
                        bytes_owed    = (code == rotd_pkg::LEN_TWO) ? 2'd1 : 2'd3;
                    end
                endcase
            end
            else
            begin
                partial_words = {partial_words[rotd_pkg::WORDS_W-9:0], b};
                bytes_owed    = bytes_owed - 2'd1;
                if (bytes_owed == 0)
                begin
                    value         = partial_words;
                    partial_words = '0;
                    entry_done    = 1'b1;
                end
            end
        end
        if (entry_done)
        begin
            word_total         = word_total + {2'b00, value};
            r.entry_valid      = 1'b1;
            r.relative_words   = value;
            r.patch_address    = base_address_reg
                                 + {word_total[rotd_pkg::SUM_W-3:0], 2'b00};
        end
        r.table_end = last;
        if (last)
            clear_decoder();
        return entry_done || last;
    endfunction

    task automatic send_byte(input logic [rotd_pkg::BYTE_W-1:0] b, input bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            tbl_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tbl_if.valid      <= 1'b1;
        tbl_if.table_byte <= b;
        tbl_if.last_byte  <= last;
        @(posedge clk);
        while (!tbl_if.ready)
            @(posedge clk);
    endtask

    task automatic issue_byte(input logic [rotd_pkg::BYTE_W-1:0] b, input bit last);
        rotd_pkg::result_t r;
        bit                ignored;
        ignored = table_ended && !last;
        send_byte(b, last);
        if (decode_table_byte(b, last, r))
            expected_results.push_back(r);
        if (!ignored)
            phase_items++;
    endtask

    task automatic drain_results();
        tbl_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_base(input logic [rotd_pkg::ADDR_OUT_W-1:0] value);
        cfg_if.valid        <= 1'b1;
        cfg_if.base_address <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid     <= 1'b0;
        base_address_reg  = value;
    endtask

    function automatic logic [rotd_pkg::BYTE_W-1:0] data_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return rotd_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [rotd_pkg::FIELD_W-1:0] payload_bits();
        case ($urandom_range(0, 7))
            0:       return 6'h00;
            1:       return 6'h3F;
            default: return rotd_pkg::FIELD_W'($urandom_range(0, 63));
        endcase
    endfunction

    // one table: mostly well formed, some padded, cut short or plain noise
    task automatic send_table();
        int                          kind;
        int                          entries;
        int                          nbytes;
        int                          noise;
        int                          e;
        int                          k;
        bit                          last;
        rotd_pkg::len_code_t         code;
        logic [rotd_pkg::BYTE_W-1:0] first;
        kind    = $urandom_range(0, 9);
        entries = $urandom_range(1, 6);
        if (kind == 9)
        begin
            noise = $urandom_range(0, 5);
            repeat (noise) issue_byte(data_byte(), 1'b0);
            issue_byte(data_byte(), 1'b1);
        end
        else
        begin
            for (e = 0; e < entries; e++)
            begin
                code   = rotd_pkg::len_code_t'($urandom_range(1, 3));
                if (kind == 8 && e == entries - 1)
                    code = rotd_pkg::len_code_t'($urandom_range(2, 3));
                nbytes = (code == rotd_pkg::LEN_ONE) ? 1 :
                         (code == rotd_pkg::LEN_TWO) ? 2 : 4;
                // cut the final entry short
                if (kind == 8 && e == entries - 1)
                    nbytes = $urandom_range(1, nbytes - 1);
                first  = {code, payload_bits()};
                for (k = 0; k < nbytes; k++)
                begin
                    last = (e == entries - 1) && (k == nbytes - 1)
                           && (kind <= 5 || kind == 8);
                    issue_byte((k == 0) ? first : data_byte(), last);
                end
            end
            if (kind == 6)
                issue_byte({rotd_pkg::LEN_PAD, payload_bits()}, 1'b1);
            if (kind == 7)
            begin
                issue_byte({rotd_pkg::LEN_PAD, payload_bits()}, 1'b0);
                noise = $urandom_range(0, 4);
                repeat (noise) issue_byte(data_byte(), 1'b0);
                issue_byte(data_byte(), 1'b1);
            end
        end
    endtask

    // result sink with random stalls
    initial
    begin
        int stall;
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_result
        rotd_pkg::result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word: entry_valid %0d relative_words %0d",
                       res_if.entry_valid, res_if.relative_words);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_if.entry_valid !== want.entry_valid)
                begin
                    $error("entry_valid: expected %0d, got %0d",
                           want.entry_valid, res_if.entry_valid);
                    error_count++;
                end
                if (res_if.relative_words !== want.relative_words)
                begin
                    $error("relative_words: expected %0h, got %0h",
                           want.relative_words, res_if.relative_words);
                    error_count++;
                end
                if (res_if.patch_address !== want.patch_address)
                begin
                    $error("patch_address: expected %0h, got %0h",
                           want.patch_address, res_if.patch_address);
                    error_count++;
                end
                if (res_if.table_end !== want.table_end)
                begin
                    $error("table_end: expected %0d, got %0d",
                           want.table_end, res_if.table_end);
                    error_count++;
                end
            end
        end
    end

    // stop a hung run: count cycles in which no word moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (tbl_if.valid && tbl_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[relative_offset_table_decoder] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [rotd_pkg::ADDR_OUT_W-1:0] bases [5];
        rotd_pkg::result_t               r;
        bit                              got;
        int                              i;
        int                              p;
        error_count = 0;
        idle_cycles = 0;
        phase_items = 0;
        no_idle     = 1'b0;
        base_address_reg = '0;
        clear_decoder();
        bases = '{32'hFFFF_FFFF, 32'h0000_0000, 32'($urandom), 32'h8000_0000, 32'($urandom)};

        rst_n               <= 1'b0;
        tbl_if.valid        <= 1'b0;
        tbl_if.table_byte   <= '0;
        tbl_if.last_byte    <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.base_address <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(directed_rows); i++)
        begin
            send_byte(directed_rows[i].table_byte, directed_rows[i].last_byte);
            got = decode_table_byte(directed_rows[i].table_byte,
                                    directed_rows[i].last_byte, r);
            if (directed_rows[i].by_hand)
            begin
                if (directed_rows[i].has_result)
                    expected_results.push_back(directed_rows[i].result);
            end
            else if (got)
                expected_results.push_back(r);
        end
        drain_results();

        for (p = 0; p < $size(bases); p++)
        begin
            write_base(bases[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                no_idle = ($urandom_range(0, 5) == 0);
                send_table();
                // hold the sender until everything owed has come back
                if (p == 2 && phase_items < 20)
                    drain_results();
            end
            no_idle = 1'b0;
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("[relative_offset_table_decoder] OK");
        else
            $display("[relative_offset_table_decoder] ERROR");
        $finish;
    end
endmodule
